// ----- sv/bcc_pkg.sv -----
// Shared constants, codes and types for the button click classifier.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int FIELD_W        = 16;
  localparam int EV_W           = 3;
  localparam int ST_W           = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int PORT_WIDTH_DEF = 16;

  localparam logic [FIELD_W-1:0] CNT_MAX = 16'hFFFF;

  // Classifier states
  localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESS   = 3'd1;
  localparam logic [ST_W-1:0] ST_RELEASE = 3'd2;
  localparam logic [ST_W-1:0] ST_DOUBLE  = 3'd3;
  localparam logic [ST_W-1:0] ST_LONG    = 3'd4;

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EV_W-1:0] EV_DOWN   = 3'd1;
  localparam logic [EV_W-1:0] EV_UP     = 3'd2;
  localparam logic [EV_W-1:0] EV_SHORT  = 3'd3;
  localparam logic [EV_W-1:0] EV_DOUBLE = 3'd4;
  localparam logic [EV_W-1:0] EV_LONG   = 3'd5;
  localparam logic [EV_W-1:0] EV_REPEAT = 3'd6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd4;

  // Register reset values
  localparam logic [FIELD_W-1:0] RST_KEY_MASK   = 16'd1;
  localparam logic [FIELD_W-1:0] RST_SHORT      = 16'd3;
  localparam logic [FIELD_W-1:0] RST_LONG       = 16'd100;
  localparam logic [FIELD_W-1:0] RST_DOUBLE_GAP = 16'd30;
  localparam logic [FIELD_W-1:0] RST_REPEAT     = 16'd20;

  typedef struct packed {
    logic [FIELD_W-1:0] key_mask;
    logic [FIELD_W-1:0] short_ticks;
    logic [FIELD_W-1:0] long_ticks;
    logic [FIELD_W-1:0] double_gap_ticks;
    logic [FIELD_W-1:0] repeat_ticks;
  } bcc_cfg_t;

endpackage

`default_nettype wire

// ----- sv/bcc_core.sv -----
// Next-state and event logic of the click classifier for one scan tick.
`timescale 1ns / 1ps
`default_nettype none

module bcc_core
  import bcc_pkg::*;
(
  input  bcc_cfg_t           cfg,
  input  logic [FIELD_W-1:0] pressed,
  input  logic [FIELD_W-1:0] prev_pressed,
  input  logic [ST_W-1:0]    state,
  input  logic [FIELD_W-1:0] hold_count,
  output logic [EV_W-1:0]    event_code,
  output logic [ST_W-1:0]    state_nxt,
  output logic [FIELD_W-1:0] hold_count_nxt
);

  logic               w_rise;
  logic               w_fall;
  logic               w_held;
  logic [FIELD_W-1:0] cnt_inc;

  assign w_rise = |(cfg.key_mask & pressed & ~prev_pressed);
  assign w_fall = |(cfg.key_mask & ~pressed & prev_pressed);
  assign w_held = |(cfg.key_mask & pressed);

  // Saturate rather than wrap
  assign cnt_inc = (hold_count != CNT_MAX) ? hold_count + 16'd1 : hold_count;

  always_comb begin
    event_code     = EV_NONE;
    state_nxt      = state;
    hold_count_nxt = hold_count;
    unique case (state)
      ST_IDLE: begin
        if (w_rise) begin
          event_code     = EV_DOWN;
          state_nxt      = ST_PRESS;
          hold_count_nxt = '0;
        end
      end
      ST_PRESS: begin
        if (w_held) begin
          hold_count_nxt = cnt_inc;
          if (cnt_inc >= cfg.long_ticks) begin
            event_code     = EV_LONG;
            state_nxt      = ST_LONG;
            hold_count_nxt = '0;
          end
        end else begin
          event_code = EV_UP;
          if (hold_count < cfg.short_ticks) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt      = ST_RELEASE;
            hold_count_nxt = '0;
          end
        end
      end
      ST_RELEASE: begin
        if (w_rise) begin
          event_code = EV_DOUBLE;
          state_nxt  = ST_DOUBLE;
        end else begin
          hold_count_nxt = cnt_inc;
          if (cnt_inc > cfg.double_gap_ticks) begin
            event_code = EV_SHORT;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_DOUBLE: begin
        if (w_fall) begin
          event_code = EV_UP;
          state_nxt  = ST_IDLE;
        end
      end
      ST_LONG: begin
        if (w_fall) begin
          event_code = EV_UP;
          state_nxt  = ST_IDLE;
        end else begin
          hold_count_nxt = cnt_inc;
          if (cnt_inc >= cfg.repeat_ticks) begin
            event_code     = EV_REPEAT;
            hold_count_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/button_click_classifier_unit.sv -----
// Top level of the button click classifier: handshakes, registers and state.
`timescale 1ns / 1ps
`default_nettype none

// One word per scan tick goes in and one result word comes out for each. A
// word is registered on entry, classified by a single pass through the
// compare-and-count logic as it moves into the output register, and held
// there until taken; a new word is taken every cycle while the output is
// free or draining. The configuration port is always ready and should
// be written only while no word is in flight.
module button_click_classifier_unit
  import bcc_pkg::*;
#(
  parameter int PORT_WIDTH = PORT_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FIELD_W-1:0]   in_port_levels,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [EV_W-1:0]           out_event_res,
  output logic [FIELD_W-1:0]        out_pressed_mask,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_W-1:0]   cfg_data
);

  localparam int ACT_W = (PORT_WIDTH < FIELD_W) ? PORT_WIDTH : FIELD_W;

  bcc_cfg_t cfg_r;

  logic               s1_valid_r;
  logic [FIELD_W-1:0] s1_levels_r;
  logic               s1_adv;

  logic [ACT_W-1:0]   prev_pressed_r;
  logic [ST_W-1:0]    state_r;
  logic [FIELD_W-1:0] hold_count_r;

  logic               out_valid_r;
  logic [EV_W-1:0]    out_event_r;
  logic [FIELD_W-1:0] out_pressed_r;

  logic [ACT_W-1:0]   pressed_act;
  logic [FIELD_W-1:0] pressed;
  logic [FIELD_W-1:0] prev_pressed;
  logic [EV_W-1:0]    event_nxt;
  logic [ST_W-1:0]    state_nxt;
  logic [FIELD_W-1:0] hold_count_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_mask         <= RST_KEY_MASK;
      cfg_r.short_ticks      <= RST_SHORT;
      cfg_r.long_ticks       <= RST_LONG;
      cfg_r.double_gap_ticks <= RST_DOUBLE_GAP;
      cfg_r.repeat_ticks     <= RST_REPEAT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_MASK:   cfg_r.key_mask         <= cfg_data;
        CFG_SHORT:      cfg_r.short_ticks      <= cfg_data;
        CFG_LONG:       cfg_r.long_ticks       <= cfg_data;
        CFG_DOUBLE_GAP: cfg_r.double_gap_ticks <= cfg_data;
        CFG_REPEAT:     cfg_r.repeat_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the output register is free or draining
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_levels_r <= in_port_levels;
    end
  end

  assign pressed_act  = ~s1_levels_r[ACT_W-1:0];
  assign pressed      = FIELD_W'(pressed_act);
  assign prev_pressed = FIELD_W'(prev_pressed_r);

  bcc_core u_core (
    .cfg            (cfg_r),
    .pressed        (pressed),
    .prev_pressed   (prev_pressed),
    .state          (state_r),
    .hold_count     (hold_count_r),
    .event_code     (event_nxt),
    .state_nxt      (state_nxt),
    .hold_count_nxt (hold_count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pressed_r <= '0;
      state_r        <= ST_IDLE;
      hold_count_r   <= '0;
      out_valid_r    <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        prev_pressed_r <= pressed_act;
        state_r        <= state_nxt;
        hold_count_r   <= hold_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_event_r   <= event_nxt;
      out_pressed_r <= pressed;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_event_r;
  assign out_pressed_mask = out_pressed_r;

endmodule

`default_nettype wire

// ----- sv/bcc_checker.sv -----
// Port-level checks for the button click classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bcc_checker
  import bcc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [EV_W-1:0]    out_event_res,
  input wire logic [FIELD_W-1:0] out_pressed_mask
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_pressed_mask))
    else $error("stalled result word changed");

  // Only defined event codes leave the block
  a_ev_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= EV_REPEAT)
    else $error("undefined event code");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A draining output must never stall the input
  a_no_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output free");

  // Without a word offered or pending, no stall is raised from an idle output
  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid |=> !in_stall)
    else $error("input stalled with nothing in flight");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_res    (out_event_res),
  .out_pressed_mask (out_pressed_mask)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the button click classifier unit.
`timescale 1ns / 1ps

module tb_top;
  import bcc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int LEN_CAP         = 200;

  typedef struct {
    logic [EV_W-1:0]    event_res;
    logic [FIELD_W-1:0] pressed_mask;
  } click_result_t;

  // Tracks the classifier state and the queue of results it should produce.
  class click_scoreboard;
    bcc_cfg_t           regs;
    logic [FIELD_W-1:0] last_pressed;
    logic [FIELD_W-1:0] hold_cnt;
    logic [ST_W-1:0]    state;
    click_result_t      expected_q[$];
    int                 errors;

    function new();
      regs.key_mask         = RST_KEY_MASK;
      regs.short_ticks      = RST_SHORT;
      regs.long_ticks       = RST_LONG;
      regs.double_gap_ticks = RST_DOUBLE_GAP;
      regs.repeat_ticks     = RST_REPEAT;
      last_pressed = '0;
      hold_cnt     = '0;
      state        = ST_IDLE;
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      case (idx)
        CFG_KEY_MASK:   regs.key_mask = data;
        CFG_SHORT:      regs.short_ticks = data;
        CFG_LONG:       regs.long_ticks = data;
        CFG_DOUBLE_GAP: regs.double_gap_ticks = data;
        CFG_REPEAT:     regs.repeat_ticks = data;
        default:        ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Count up but stick at the top value.
    function void bump();
      if (hold_cnt != CNT_MAX) hold_cnt++;
    endfunction

    function void note_tick(logic [FIELD_W-1:0] levels);
      logic [FIELD_W-1:0] pressed;
      logic               w_rise, w_fall, w_held;
      click_result_t      res;
      pressed = ~levels;
      w_rise  = |(regs.key_mask & pressed & ~last_pressed);
      w_fall  = |(regs.key_mask & ~pressed & last_pressed);
      w_held  = |(regs.key_mask & pressed);
      res.event_res    = EV_NONE;
      res.pressed_mask = pressed;
      last_pressed     = pressed;
      case (state)
        ST_IDLE: begin
          if (w_rise) begin
            res.event_res = EV_DOWN;
            state = ST_PRESS;
            hold_cnt = '0;
          end
        end
        ST_PRESS: begin
          if (w_held) begin
            bump();
            if (hold_cnt >= regs.long_ticks) begin
              res.event_res = EV_LONG;
              state = ST_LONG;
              hold_cnt = '0;
            end
          end else begin
            res.event_res = EV_UP;
            if (hold_cnt < regs.short_ticks) begin
              state = ST_IDLE;
            end else begin
              state = ST_RELEASE;
              hold_cnt = '0;
            end
          end
        end
        ST_RELEASE: begin
          if (w_rise) begin
            res.event_res = EV_DOUBLE;
            state = ST_DOUBLE;
          end else begin
            bump();
            if (hold_cnt > regs.double_gap_ticks) begin
              res.event_res = EV_SHORT;
              state = ST_IDLE;
            end
          end
        end
        ST_DOUBLE: begin
          if (w_fall) begin
            res.event_res = EV_UP;
            state = ST_IDLE;
          end
        end
        ST_LONG: begin
          if (w_fall) begin
            res.event_res = EV_UP;
            state = ST_IDLE;
          end else begin
            bump();
            if (hold_cnt >= regs.repeat_ticks) begin
              hold_cnt = '0;
              res.event_res = EV_REPEAT;
            end
          end
        end
        default: state = ST_IDLE;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [EV_W-1:0] ev, logic [FIELD_W-1:0] mask);
      click_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: event_res %0d, pressed_mask %h", ev, mask);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (ev !== exp_res.event_res) begin
          $error("event_res: expected %0d, got %0d", exp_res.event_res, ev);
          errors++;
        end
        if (mask !== exp_res.pressed_mask) begin
          $error("pressed_mask: expected %h, got %h", exp_res.pressed_mask, mask);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FIELD_W-1:0]   in_port_levels;
  logic                 out_valid;
  logic                 out_stall;
  logic [EV_W-1:0]      out_event_res;
  logic [FIELD_W-1:0]   out_pressed_mask;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;

  click_scoreboard sb;
  bit              idle_en = 1'b1;
  bit              hold_off_req = 1'b0;
  int              words_sent = 0;

  always #2 clk = ~clk;

  button_click_classifier_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_port_levels   (in_port_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_pressed_mask (out_pressed_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Sample both channels on the edge, before any of its updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_event_res, out_pressed_mask);
      if (in_valid && !in_stall) sb.note_tick(in_port_levels);
    end
  end

  // Result sink: stall for a random spell before each word, or a long one on request.
  initial begin : result_sink
    int wait_cycles;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_cycles = HOLD_OFF_CYCLES;
      end else begin
        wait_cycles = idle_en ? $urandom_range(0, 14) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_word(input logic [FIELD_W-1:0] levels);
    int gap;
    gap = idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_port_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop the input and let every outstanding result drain.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [FIELD_W-1:0] mask, input logic [FIELD_W-1:0] short_t,
                              input logic [FIELD_W-1:0] long_t, input logic [FIELD_W-1:0] gap_t,
                              input logic [FIELD_W-1:0] rep_t);
    drain();
    write_reg(CFG_KEY_MASK, mask);
    write_reg(CFG_SHORT, short_t);
    write_reg(CFG_LONG, long_t);
    write_reg(CFG_DOUBLE_GAP, gap_t);
    write_reg(CFG_REPEAT, rep_t);
  endtask

  function automatic logic [FIELD_W-1:0] pick_keys();
    logic [FIELD_W-1:0] m, k;
    m = sb.regs.key_mask;
    k = FIELD_W'($urandom()) & m;
    if (k == '0) k = m & (~m + 1'b1);
    if (m == '0) k = FIELD_W'($urandom());
    return k;
  endfunction

  function automatic int press_len();
    int s, l, r, n;
    s = int'(sb.regs.short_ticks);
    l = int'(sb.regs.long_ticks);
    r = int'(sb.regs.repeat_ticks);
    case ($urandom_range(0, 3))
      0:       n = $urandom_range(1, s + 2);
      1:       n = $urandom_range(s, l + 1);
      default: n = l + $urandom_range(0, 3 * r + 2);
    endcase
    return (n > LEN_CAP) ? $urandom_range(1, LEN_CAP) : n;
  endfunction

  // Aim around the double-click window, where the boundary lies.
  function automatic int gap_len();
    int g, n;
    g = int'(sb.regs.double_gap_ticks);
    if ($urandom_range(0, 1) == 0) n = $urandom_range(0, g + 2);
    else n = g + $urandom_range(0, 3);
    return (n > LEN_CAP) ? $urandom_range(0, LEN_CAP) : n;
  endfunction

  // Hold the keys, with noise on unwatched pins and now and then extra watched keys.
  task automatic hold_for(input logic [FIELD_W-1:0] keys, input int n);
    logic [FIELD_W-1:0] pressed;
    repeat (n) begin
      pressed = keys | (FIELD_W'($urandom()) & ~sb.regs.key_mask);
      if ($urandom_range(0, 7) == 0) pressed |= FIELD_W'($urandom()) & sb.regs.key_mask;
      send_word(~pressed);
    end
  endtask

  // Release the watched keys; a rare glitch breaks the sequence.
  task automatic release_for(input int n);
    logic [FIELD_W-1:0] pressed;
    repeat (n) begin
      pressed = FIELD_W'($urandom()) & ~sb.regs.key_mask;
      if ($urandom_range(0, 15) == 0) pressed |= FIELD_W'($urandom()) & sb.regs.key_mask;
      send_word(~pressed);
    end
  endtask

  task automatic random_phase(input int n_words);
    int target, pick;
    target = words_sent + n_words;
    while (words_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_word(FIELD_W'($urandom()));
      end else begin
        hold_for(pick_keys(), press_len());
        release_for(gap_len());
        if (pick > 5) begin
          hold_for(pick_keys(), press_len());
          release_for(gap_len());
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [FIELD_W-1:0] walk[$];
    sb             = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_port_levels <= '1;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_KEY_MASK;
    cfg_data       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short periods so that every event shows up within a few ticks.
    apply_config(16'h0003, 16'd1, 16'd3, 16'd2, 16'd2);
    for (int i = CFG_REPEAT + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), FIELD_W'($urandom()));
    walk = '{16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF,
             16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFD, 16'hFFFF,
             16'hFFFC, 16'hFFFC, 16'hFFFC, 16'hFFFC, 16'hFFFC, 16'hFFFC, 16'hFFFF};
    foreach (walk[i]) send_word(walk[i]);

    // Zero long and repeat periods behave as one tick.
    apply_config(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    walk = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h5555, 16'hFFFF, 16'hFFFF};
    foreach (walk[i]) send_word(walk[i]);

    apply_config(RST_KEY_MASK, RST_SHORT, RST_LONG, RST_DOUBLE_GAP, RST_REPEAT);
    random_phase(350);

    apply_config(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd1);
    idle_en = 1'b0;
    random_phase(250);
    idle_en = 1'b1;

    apply_config(FIELD_W'($urandom()), FIELD_W'($urandom_range(0, 6)),
                 FIELD_W'($urandom_range(1, 24)), FIELD_W'($urandom_range(0, 12)),
                 FIELD_W'($urandom_range(1, 6)));
    random_phase(250);

    apply_config(FIELD_W'($urandom()), FIELD_W'($urandom_range(0, 6)),
                 FIELD_W'($urandom_range(1, 24)), FIELD_W'($urandom_range(0, 12)),
                 FIELD_W'($urandom_range(1, 6)));
    random_phase(250);

    // Hold the sink off so the block fills and pushes back on its input.
    apply_config(16'h8000, 16'd2, 16'd12, 16'd5, 16'd3);
    hold_off_req = 1'b1;
    random_phase(250);

    apply_config(16'h0000, FIELD_W'($urandom_range(0, 6)), FIELD_W'($urandom_range(1, 24)),
                 FIELD_W'($urandom_range(0, 12)), FIELD_W'($urandom_range(1, 6)));
    random_phase(60);

    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
    random_phase(80);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bcc_pkg.sv
sv/bcc_core.sv
sv/button_click_classifier_unit.sv
sv/bcc_checker.sv
test/tb_top.sv
